@@ hw/rtl/gru_pkg.sv @@
// Shared types, codes and activation tables for the GRU reuse scorer.
`timescale 1ns / 1ps
package gru_pkg;

  // Width of an operand index: covers the scratch store of both MLP layers.
  localparam int IDX_W = 7;
  localparam int WADDR_W = 12;

  // Exponential base for the activation tables, Q2.30.
  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned EXP_STEP = 64'd1008687096;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ACCESS = 2'd1,
    KIND_PAGE   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Operand source of a multiply-accumulate term.
  typedef enum logic [2:0] {
    SRC_ACCESS,
    SRC_PAGE,
    SRC_HIDDEN,
    SRC_RH,
    SRC_SCRATCH,
    SRC_BIAS
  } src_t;

  // Action the datapath takes once an accumulation is finished.
  typedef enum logic [3:0] {
    POST_NONE,
    POST_R,
    POST_Z,
    POST_CAND,
    POST_CAP,
    POST_MUL_RH,
    POST_MUL_NEW,
    POST_MUL_OLD,
    POST_WR_RH,
    POST_WR_H,
    POST_RELU,
    POST_OUT
  } post_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_DRAIN,
    S_FIN,
    S_HREAD,
    S_HCAP,
    S_MUL1,
    S_MUL2,
    S_WRITE
  } state_t;

  typedef enum logic [2:0] {
    PH_R,
    PH_Z,
    PH_N,
    PH_FC1,
    PH_FC2,
    PH_OUT
  } phase_t;

  // One accepted input transfer.
  typedef struct packed {
    logic                accept;
    kind_t               kind;
    logic [11:0]         weight_index;
    logic [2:0]          element_index;
    logic signed [15:0]  value;
    logic                last;
  } item_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic               issue;
    logic               first;
    src_t               src;
    logic [WADDR_W-1:0] waddr;
    logic [IDX_W-1:0]   idx;
    post_t              post;
  } cmd_t;

  typedef logic [255:0][15:0] tab_t;

  // Restoring shift-and-subtract division, used only while the tables are built.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Builds the sigmoid (Q0.16) or tanh (Q4.12) table; entry k covers x = -8 + k/16.
  function automatic tab_t build_tab(input logic tanh_sel);
    longint unsigned ex [257];
    longint unsigned e;
    longint unsigned den;
    longint unsigned s;
    longint unsigned e2;
    longint unsigned den2;
    longint unsigned t;
    int a;
    tab_t tab;
    ex[0] = Q30;
    for (int k = 1; k < 257; k++) begin
      ex[k] = (ex[k-1] * EXP_STEP + (Q30 >> 1)) >> 30;
    end
    for (int k = 0; k < 256; k++) begin
      a = (k >= 128) ? k - 128 : 128 - k;
      e = ex[a];
      den = Q30 + e;
      s = (k >= 128) ? udiv((Q30 << 16) + (den >> 1), den)
                     : udiv((e << 16) + (den >> 1), den);
      e2 = ex[2 * a];
      den2 = Q30 + e2;
      t = udiv(64'd4096 * (Q30 - e2) + (den2 >> 1), den2);
      if (tanh_sel) begin
        tab[k] = (k >= 128) ? t[15:0] : 16'(~t[15:0] + 16'd1);
      end else begin
        tab[k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
      end
    end
    return tab;
  endfunction

  // Saturates a 33-bit sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Accumulator to Q4.12: floor shift by 12, saturated to 16 bits.
  function automatic logic signed [15:0] to_q12(input logic signed [31:0] acc);
    logic signed [19:0] sh;
    sh = acc[31:12];
    if (sh > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (sh < -20'sd32768) begin
      return 16'sh8000;
    end
    return sh[15:0];
  endfunction

  // Saturates a 19-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ hw/rtl/gru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gru_ctrl.sv @@
// Sequencer that walks the GRU step and the scorer MLP one term at a time.
`timescale 1ns / 1ps
module gru_ctrl #(
  parameter int HIDDEN_UNITS = 16,
  parameter int ACCESS_FEATURES = 8,
  parameter int PAGE_FEATURES = 8,
  parameter int FIRST_LAYER_UNITS = 32,
  parameter int SECOND_LAYER_UNITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  gru_pkg::item_t item,
  output logic           busy,
  output gru_pkg::cmd_t  cmd
);

  localparam int H = HIDDEN_UNITS;
  localparam int A = ACCESS_FEATURES;
  localparam int P = PAGE_FEATURES;
  localparam int F1 = FIRST_LAYER_UNITS;
  localparam int F2 = SECOND_LAYER_UNITS;
  localparam int A_WIR = 0;
  localparam int A_WIZ = A_WIR + H * A;
  localparam int A_WIN = A_WIZ + H * A;
  localparam int A_WHR = A_WIN + H * A;
  localparam int A_WHZ = A_WHR + H * H;
  localparam int A_WHN = A_WHZ + H * H;
  localparam int A_BIR = A_WHN + H * H;
  localparam int A_BIRH = A_BIR + H;
  localparam int A_BIZ = A_BIRH + H;
  localparam int A_BIZH = A_BIZ + H;
  localparam int A_BIN = A_BIZH + H;
  localparam int A_BHN = A_BIN + H;
  localparam int A_FC1W = A_BHN + H;
  localparam int A_FC1B = A_FC1W + F1 * (H + P);
  localparam int A_FC2W = A_FC1B + F1;
  localparam int A_FC2B = A_FC2W + F2 * F1;
  localparam int A_OUTW = A_FC2B + F2;
  localparam int A_OUTB = A_OUTW + F2;

  gru_pkg::state_t state, state_next;
  gru_pkg::phase_t phase, phase_next;
  logic [gru_pkg::IDX_W-1:0] unit, unit_next;
  logic [gru_pkg::IDX_W-1:0] j, j_next;
  logic [1:0] seg, seg_next;
  logic drain, drain_next;

  // Operand source of each segment of a row.
  function automatic gru_pkg::src_t seg_src(gru_pkg::phase_t ph, logic [1:0] s);
    gru_pkg::src_t r;
    r = gru_pkg::SRC_BIAS;
    unique case (ph)
      gru_pkg::PH_R, gru_pkg::PH_Z: begin
        if (s == 2'd0) r = gru_pkg::SRC_ACCESS;
        else if (s == 2'd1) r = gru_pkg::SRC_HIDDEN;
      end
      gru_pkg::PH_N: begin
        if (s == 2'd0) r = gru_pkg::SRC_ACCESS;
        else if (s == 2'd1) r = gru_pkg::SRC_RH;
      end
      gru_pkg::PH_FC1: begin
        if (s == 2'd0) r = gru_pkg::SRC_HIDDEN;
        else if (s == 2'd1) r = gru_pkg::SRC_PAGE;
      end
      gru_pkg::PH_FC2, gru_pkg::PH_OUT: begin
        if (s == 2'd0) r = gru_pkg::SRC_SCRATCH;
      end
      default: r = gru_pkg::SRC_BIAS;
    endcase
    return r;
  endfunction

  // Number of terms in each segment; a zero length ends the row.
  function automatic int seg_len(gru_pkg::phase_t ph, logic [1:0] s);
    int r;
    r = 0;
    unique case (ph)
      gru_pkg::PH_R, gru_pkg::PH_Z, gru_pkg::PH_N: begin
        r = (s == 2'd0) ? A : (s == 2'd1) ? H : 1;
      end
      gru_pkg::PH_FC1: begin
        r = (s == 2'd0) ? H : (s == 2'd1) ? P : (s == 2'd2) ? 1 : 0;
      end
      gru_pkg::PH_FC2: begin
        r = (s == 2'd0) ? F1 : (s == 2'd1) ? 1 : 0;
      end
      gru_pkg::PH_OUT: begin
        r = (s == 2'd0) ? F2 : (s == 2'd1) ? 1 : 0;
      end
      default: r = 0;
    endcase
    return r;
  endfunction

  // First weight address of each segment.
  function automatic int seg_base(gru_pkg::phase_t ph, logic [1:0] s, int u);
    int r;
    r = 0;
    unique case (ph)
      gru_pkg::PH_R: begin
        r = (s == 2'd0) ? A_WIR + u * A : (s == 2'd1) ? A_WHR + u * H :
            (s == 2'd2) ? A_BIR + u : A_BIRH + u;
      end
      gru_pkg::PH_Z: begin
        r = (s == 2'd0) ? A_WIZ + u * A : (s == 2'd1) ? A_WHZ + u * H :
            (s == 2'd2) ? A_BIZ + u : A_BIZH + u;
      end
      gru_pkg::PH_N: begin
        r = (s == 2'd0) ? A_WIN + u * A : (s == 2'd1) ? A_WHN + u * H :
            (s == 2'd2) ? A_BIN + u : A_BHN + u;
      end
      gru_pkg::PH_FC1: begin
        r = (s == 2'd0) ? A_FC1W + u * (H + P) : (s == 2'd1) ? A_FC1W + u * (H + P) + H :
            A_FC1B + u;
      end
      gru_pkg::PH_FC2: begin
        r = (s == 2'd0) ? A_FC2W + u * F1 : A_FC2B + u;
      end
      gru_pkg::PH_OUT: begin
        r = (s == 2'd0) ? A_OUTW : A_OUTB;
      end
      default: r = 0;
    endcase
    return r;
  endfunction

  // Second-layer activations sit after the first layer in the scratch store.
  function automatic int seg_off(gru_pkg::phase_t ph);
    return (ph == gru_pkg::PH_OUT) ? F1 : 0;
  endfunction

  logic row_end;
  logic seg_done;
  logic unit_end_h;
  logic unit_end_f1;
  logic unit_end_f2;

  assign row_end = (int'(j) == seg_len(phase, seg) - 1);
  assign seg_done = (seg == 2'd3) || (seg_len(phase, seg + 2'd1) == 0);
  assign unit_end_h = (int'(unit) == H - 1);
  assign unit_end_f1 = (int'(unit) == F1 - 1);
  assign unit_end_f2 = (int'(unit) == F2 - 1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    phase_next = phase;
    unit_next = unit;
    j_next = j;
    seg_next = seg;
    drain_next = drain;
    unique case (state)
      gru_pkg::S_IDLE: begin
        j_next = '0;
        seg_next = '0;
        unit_next = '0;
        if (item.accept && item.last && item.kind == gru_pkg::KIND_ACCESS) begin
          phase_next = gru_pkg::PH_R;
          state_next = gru_pkg::S_ROW;
        end else if (item.accept && item.last && item.kind == gru_pkg::KIND_PAGE) begin
          phase_next = gru_pkg::PH_FC1;
          state_next = gru_pkg::S_ROW;
        end
      end
      gru_pkg::S_ROW: begin
        if (row_end) begin
          j_next = '0;
          if (seg_done) begin
            seg_next = '0;
            drain_next = 1'b0;
            state_next = gru_pkg::S_DRAIN;
          end else begin
            seg_next = seg + 2'd1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      gru_pkg::S_DRAIN: begin
        drain_next = 1'b1;
        if (drain) begin
          state_next = gru_pkg::S_FIN;
        end
      end
      gru_pkg::S_FIN: begin
        unique case (phase)
          gru_pkg::PH_R: begin
            phase_next = gru_pkg::PH_Z;
            state_next = gru_pkg::S_ROW;
          end
          gru_pkg::PH_Z, gru_pkg::PH_N: begin
            state_next = gru_pkg::S_HREAD;
          end
          gru_pkg::PH_FC1: begin
            state_next = gru_pkg::S_ROW;
            if (unit_end_f1) begin
              unit_next = '0;
              phase_next = gru_pkg::PH_FC2;
            end else begin
              unit_next = unit + 1'b1;
            end
          end
          gru_pkg::PH_FC2: begin
            state_next = gru_pkg::S_ROW;
            if (unit_end_f2) begin
              unit_next = '0;
              phase_next = gru_pkg::PH_OUT;
            end else begin
              unit_next = unit + 1'b1;
            end
          end
          default: begin
            state_next = gru_pkg::S_IDLE;
          end
        endcase
      end
      gru_pkg::S_HREAD: state_next = gru_pkg::S_HCAP;
      gru_pkg::S_HCAP: state_next = gru_pkg::S_MUL1;
      gru_pkg::S_MUL1: begin
        state_next = (phase == gru_pkg::PH_N) ? gru_pkg::S_MUL2 : gru_pkg::S_WRITE;
      end
      gru_pkg::S_MUL2: state_next = gru_pkg::S_WRITE;
      gru_pkg::S_WRITE: begin
        if (phase == gru_pkg::PH_Z) begin
          state_next = gru_pkg::S_ROW;
          if (unit_end_h) begin
            unit_next = '0;
            phase_next = gru_pkg::PH_N;
          end else begin
            unit_next = unit + 1'b1;
            phase_next = gru_pkg::PH_R;
          end
        end else if (unit_end_h) begin
          state_next = gru_pkg::S_IDLE;
        end else begin
          unit_next = unit + 1'b1;
          state_next = gru_pkg::S_ROW;
        end
      end
      default: state_next = gru_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    cmd.src = gru_pkg::SRC_HIDDEN;
    cmd.post = gru_pkg::POST_NONE;
    cmd.idx = unit;
    unique case (state)
      gru_pkg::S_ROW: begin
        cmd.issue = 1'b1;
        cmd.first = (seg == 2'd0) && (j == '0);
        cmd.src = seg_src(phase, seg);
        cmd.waddr = gru_pkg::WADDR_W'(seg_base(phase, seg, int'(unit)) + int'(j));
        cmd.idx = gru_pkg::IDX_W'(seg_off(phase) + int'(j));
      end
      gru_pkg::S_FIN: begin
        unique case (phase)
          gru_pkg::PH_R: cmd.post = gru_pkg::POST_R;
          gru_pkg::PH_Z: cmd.post = gru_pkg::POST_Z;
          gru_pkg::PH_N: cmd.post = gru_pkg::POST_CAND;
          gru_pkg::PH_FC1: cmd.post = gru_pkg::POST_RELU;
          gru_pkg::PH_FC2: begin
            cmd.post = gru_pkg::POST_RELU;
            cmd.idx = gru_pkg::IDX_W'(F1 + int'(unit));
          end
          default: cmd.post = gru_pkg::POST_OUT;
        endcase
      end
      gru_pkg::S_HCAP: cmd.post = gru_pkg::POST_CAP;
      gru_pkg::S_MUL1: begin
        cmd.post = (phase == gru_pkg::PH_N) ? gru_pkg::POST_MUL_NEW : gru_pkg::POST_MUL_RH;
      end
      gru_pkg::S_MUL2: cmd.post = gru_pkg::POST_MUL_OLD;
      gru_pkg::S_WRITE: begin
        cmd.post = (phase == gru_pkg::PH_N) ? gru_pkg::POST_WR_H : gru_pkg::POST_WR_RH;
      end
      default: cmd.post = gru_pkg::POST_NONE;
    endcase
  end

  assign busy = (state != gru_pkg::S_IDLE);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gru_pkg::S_IDLE;
      phase <= gru_pkg::PH_R;
      unit <= '0;
      j <= '0;
      seg <= '0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      unit <= unit_next;
      j <= j_next;
      seg <= seg_next;
      drain <= drain_next;
    end
  end

endmodule

@@ hw/rtl/gru_datapath.sv @@
// Datapath: parameter memory, vector stores, shared MAC and activation stage.
`timescale 1ns / 1ps
module gru_datapath #(
  parameter int HIDDEN_UNITS = 16,
  parameter int ACCESS_FEATURES = 8,
  parameter int PAGE_FEATURES = 8,
  parameter int FIRST_LAYER_UNITS = 32,
  parameter int SECOND_LAYER_UNITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  gru_pkg::item_t item,
  input  gru_pkg::cmd_t  cmd,
  output logic           done,
  output logic [15:0]    reuse_probability
);

  localparam int H = HIDDEN_UNITS;
  localparam int SD = FIRST_LAYER_UNITS + SECOND_LAYER_UNITS;
  localparam int HAW = (H > 1) ? $clog2(H) : 1;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int AIW = (ACCESS_FEATURES > 1) ? $clog2(ACCESS_FEATURES) : 1;
  localparam int PIW = (PAGE_FEATURES > 1) ? $clog2(PAGE_FEATURES) : 1;
  localparam gru_pkg::tab_t SIG_TAB = gru_pkg::build_tab(1'b0);
  localparam gru_pkg::tab_t TANH_TAB = gru_pkg::build_tab(1'b1);

  logic [15:0] w_q;
  logic [15:0] hid_q;
  logic [15:0] rh_q;
  logic [15:0] z_q;
  logic [15:0] scr_q;
  logic [H-1:0] hvalid;
  logic hvalid_q;
  logic signed [15:0] abuf [ACCESS_FEATURES];
  logic signed [15:0] pbuf [PAGE_FEATURES];
  logic signed [15:0] abuf_q;
  logic signed [15:0] pbuf_q;
  logic v1, first1, v2, first2;
  gru_pkg::src_t src1;
  logic signed [15:0] op;
  logic signed [15:0] hval;
  logic signed [31:0] prod;
  logic signed [31:0] acc;
  logic signed [15:0] q12;
  logic [7:0] tidx;
  logic [15:0] sig_val;
  logic [15:0] tanh_val;
  logic signed [15:0] relu;
  logic [15:0] r_reg;
  logic [15:0] z_reg;
  logic signed [15:0] h_reg;
  logic signed [15:0] cand_reg;
  logic signed [17:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [33:0] m1, m2;
  logic signed [34:0] mix;
  logic signed [15:0] rh_new;
  logic signed [15:0] h_new;
  logic load_we;

  assign load_we = item.accept && (item.kind == gru_pkg::KIND_LOAD);

  gru_ram #(.WIDTH(16), .DEPTH(4096)) u_wmem (
    .clk(clk), .we(load_we), .waddr(item.weight_index), .wdata(item.value),
    .raddr(cmd.waddr), .rdata(w_q)
  );

  gru_ram #(.WIDTH(16), .DEPTH(H)) u_hid (
    .clk(clk), .we(cmd.post == gru_pkg::POST_WR_H), .waddr(cmd.idx[HAW-1:0]),
    .wdata(h_new), .raddr(cmd.idx[HAW-1:0]), .rdata(hid_q)
  );

  gru_ram #(.WIDTH(16), .DEPTH(H)) u_rh (
    .clk(clk), .we(cmd.post == gru_pkg::POST_WR_RH), .waddr(cmd.idx[HAW-1:0]),
    .wdata(rh_new), .raddr(cmd.idx[HAW-1:0]), .rdata(rh_q)
  );

  gru_ram #(.WIDTH(16), .DEPTH(H)) u_z (
    .clk(clk), .we(cmd.post == gru_pkg::POST_Z), .waddr(cmd.idx[HAW-1:0]),
    .wdata(sig_val), .raddr(cmd.idx[HAW-1:0]), .rdata(z_q)
  );

  gru_ram #(.WIDTH(16), .DEPTH(SD)) u_scr (
    .clk(clk), .we(cmd.post == gru_pkg::POST_RELU), .waddr(cmd.idx[SAW-1:0]),
    .wdata(relu), .raddr(cmd.idx[SAW-1:0]), .rdata(scr_q)
  );

  // Hidden entries read as zero until written after reset or a clear.
  always_ff @(posedge clk) begin
    if (rst || (item.accept && item.kind == gru_pkg::KIND_CLEAR)) begin
      hvalid <= '0;
    end else if (cmd.post == gru_pkg::POST_WR_H) begin
      hvalid[cmd.idx[HAW-1:0]] <= 1'b1;
    end
    hvalid_q <= hvalid[cmd.idx[HAW-1:0]];
  end

  // Feature buffers: elements beyond the vector length are dropped.
  always_ff @(posedge clk) begin
    if (item.accept && item.kind == gru_pkg::KIND_ACCESS &&
        {1'b0, item.element_index} < 4'(ACCESS_FEATURES)) begin
      abuf[item.element_index[AIW-1:0]] <= item.value;
    end
    if (item.accept && item.kind == gru_pkg::KIND_PAGE &&
        {1'b0, item.element_index} < 4'(PAGE_FEATURES)) begin
      pbuf[item.element_index[PIW-1:0]] <= item.value;
    end
    abuf_q <= abuf[cmd.idx[AIW-1:0]];
    pbuf_q <= pbuf[cmd.idx[PIW-1:0]];
  end

  assign hval = hvalid_q ? $signed(hid_q) : 16'sd0;

  // Operand selection for the term whose weight was just read.
  always_comb begin
    unique case (src1)
      gru_pkg::SRC_ACCESS: op = abuf_q;
      gru_pkg::SRC_PAGE: op = pbuf_q;
      gru_pkg::SRC_HIDDEN: op = hval;
      gru_pkg::SRC_RH: op = $signed(rh_q);
      gru_pkg::SRC_SCRATCH: op = $signed(scr_q);
      default: op = 16'sd4096;
    endcase
  end

  // MAC pipeline: read, multiply, saturating accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
    first1 <= cmd.first;
    src1 <= cmd.src;
    first2 <= first1;
    prod <= $signed(w_q) * op;
    if (v2) begin
      acc <= gru_pkg::sat32(33'(first2 ? 32'sd0 : acc) + 33'(prod));
    end
  end

  // Activation lookup on the finished accumulator.
  assign q12 = gru_pkg::to_q12(acc);
  assign tidx = {~q12[15], q12[14:8]};
  assign sig_val = SIG_TAB[tidx];
  assign tanh_val = TANH_TAB[tidx];
  assign relu = q12[15] ? 16'sd0 : q12;

  // Shared gate multiplier.
  always_comb begin
    unique case (cmd.post)
      gru_pkg::POST_MUL_RH: begin
        mul_a = $signed({2'b00, r_reg});
        mul_b = h_reg;
      end
      gru_pkg::POST_MUL_NEW: begin
        mul_a = $signed(18'h10000 - {2'b00, z_reg});
        mul_b = cand_reg;
      end
      default: begin
        mul_a = $signed({2'b00, z_reg});
        mul_b = h_reg;
      end
    endcase
  end

  assign mix = 35'(m1) + 35'(m2);
  assign rh_new = gru_pkg::sat16(19'($signed(m1[33:16])));
  assign h_new = gru_pkg::sat16(mix[34:16]);

  // Gate registers and result output.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.post == gru_pkg::POST_OUT);
    end
    if (cmd.post == gru_pkg::POST_R) r_reg <= sig_val;
    if (cmd.post == gru_pkg::POST_CAND) cand_reg <= $signed(tanh_val);
    if (cmd.post == gru_pkg::POST_CAP) begin
      h_reg <= hval;
      z_reg <= z_q;
    end
    if (cmd.post == gru_pkg::POST_MUL_RH || cmd.post == gru_pkg::POST_MUL_NEW) begin
      m1 <= mul_a * mul_b;
    end
    if (cmd.post == gru_pkg::POST_MUL_OLD) m2 <= mul_a * mul_b;
    if (cmd.post == gru_pkg::POST_OUT) reuse_probability <= sig_val;
  end

endmodule

@@ hw/rtl/gru_cell_with_reuse_scorer.sv @@
// Top level of the GRU cell with MLP reuse scorer.
`timescale 1ns / 1ps
// A transfer is taken when start is high and busy is low. Weight loads, feature
// elements without last, and clears leave busy low. An access element with last
// runs a GRU step on one shared multiply-accumulate unit, one weight word per
// cycle within a row from the parameter memory read port. A page element with
// last runs the scorer, after which reuse_probability is shown for one cycle
// with done high; the receiver must take it then. busy stays high for the whole
// computation.
module gru_cell_with_reuse_scorer #(
  parameter int HIDDEN_UNITS = 16,
  parameter int ACCESS_FEATURES = 8,
  parameter int PAGE_FEATURES = 8,
  parameter int FIRST_LAYER_UNITS = 32,
  parameter int SECOND_LAYER_UNITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [11:0]        weight_index,
  input  logic [2:0]         element_index,
  input  logic signed [15:0] value,
  input  logic               last,
  output logic               done,
  output logic [15:0]        reuse_probability
);

  gru_pkg::item_t item;
  gru_pkg::cmd_t cmd;

  // Input transfer.
  always_comb begin
    item.accept = start && !busy;
    item.kind = gru_pkg::kind_t'(kind);
    item.weight_index = weight_index;
    item.element_index = element_index;
    item.value = value;
    item.last = last;
  end

  gru_ctrl #(
    .HIDDEN_UNITS(HIDDEN_UNITS), .ACCESS_FEATURES(ACCESS_FEATURES),
    .PAGE_FEATURES(PAGE_FEATURES), .FIRST_LAYER_UNITS(FIRST_LAYER_UNITS),
    .SECOND_LAYER_UNITS(SECOND_LAYER_UNITS)
  ) u_ctrl (
    .clk(clk), .rst(rst), .item(item), .busy(busy), .cmd(cmd)
  );

  gru_datapath #(
    .HIDDEN_UNITS(HIDDEN_UNITS), .ACCESS_FEATURES(ACCESS_FEATURES),
    .PAGE_FEATURES(PAGE_FEATURES), .FIRST_LAYER_UNITS(FIRST_LAYER_UNITS),
    .SECOND_LAYER_UNITS(SECOND_LAYER_UNITS)
  ) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .done(done),
    .reuse_probability(reuse_probability)
  );

  // A result comes only out of a computation in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a computation");

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // A vector with last starts work in the next cycle.
  a_start_work: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && last &&
       (kind == gru_pkg::KIND_ACCESS || kind == gru_pkg::KIND_PAGE)) |=> busy)
    else $error("computation did not start");

  // Reset leaves the block idle and silent.
  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the GRU cell with MLP reuse scorer.
`timescale 1ns / 1ps
module tb;

  // Block sizes and the parameter memory layout.
  localparam int HU = 16;
  localparam int AF = 8;
  localparam int PF = 8;
  localparam int L1 = 32;
  localparam int L2 = 16;
  localparam int SIN = HU + PF;
  localparam int W_IR = 0;
  localparam int W_IZ = W_IR + HU * AF;
  localparam int W_IN = W_IZ + HU * AF;
  localparam int W_HR = W_IN + HU * AF;
  localparam int W_HZ = W_HR + HU * HU;
  localparam int W_HN = W_HZ + HU * HU;
  localparam int B_IR = W_HN + HU * HU;
  localparam int B_IRH = B_IR + HU;
  localparam int B_IZ = B_IRH + HU;
  localparam int B_IZH = B_IZ + HU;
  localparam int B_IN = B_IZH + HU;
  localparam int B_HN = B_IN + HU;
  localparam int FC1_W = B_HN + HU;
  localparam int FC1_B = FC1_W + L1 * SIN;
  localparam int FC2_W = FC1_B + L1;
  localparam int FC2_B = FC2_W + L2 * L1;
  localparam int OUT_W = FC2_B + L2;
  localparam int OUT_B = OUT_W + L2;
  localparam int USED_WORDS = OUT_B + 1;
  localparam int RANDOM_ITEMS = 1050;

  // Predicts reuse probabilities and checks them against the block.
  class reuse_scoreboard;
    logic [15:0] wmem [4096];
    shortint hidden [HU];
    shortint acc_feat [AF];
    shortint page_feat [PF];
    shortint opnd [32];
    logic [15:0] sig_lut [256];
    shortint tanh_lut [256];
    logic [15:0] prob_q [$];
    int errors;

    function new();
      longint unsigned ex [257];
      longint unsigned e, den, s, e2, den2, t;
      int a;
      errors = 0;
      foreach (hidden[i]) hidden[i] = 0;
      ex[0] = 64'd1073741824;
      for (int k = 1; k < 257; k++) begin
        ex[k] = (ex[k-1] * 64'd1008687096 + 64'd536870912) >> 30;
      end
      for (int k = 0; k < 256; k++) begin
        a = (k >= 128) ? k - 128 : 128 - k;
        e = ex[a];
        den = ex[0] + e;
        s = (k >= 128) ? (((ex[0] << 16) + den / 2) / den) : (((e << 16) + den / 2) / den);
        e2 = ex[2 * a];
        den2 = ex[0] + e2;
        t = (64'd4096 * (ex[0] - e2) + den2 / 2) / den2;
        sig_lut[k] = (s > 64'd65535) ? 16'hFFFF : s[15:0];
        tanh_lut[k] = (k >= 128) ? shortint'(t) : -shortint'(t);
      end
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function shortint sat16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return shortint'(v);
    endfunction

    function longint word(int addr);
      return longint'($signed(wmem[addr % 4096]));
    endfunction

    // Saturating dot product of a memory row with the operand vector.
    function int mac(int acc, int base, int n);
      for (int i = 0; i < n; i++) begin
        acc = sat32(longint'(acc) + word(base + i) * longint'(opnd[i]));
      end
      return acc;
    endfunction

    function int add_bias(int acc, int addr);
      return sat32(longint'(acc) + word(addr) * 4096);
    endfunction

    function shortint q12(int acc);
      return sat16(longint'(acc) >>> 12);
    endfunction

    function int lut_idx(shortint x);
      return (int'(x) + 32768) >> 8;
    endfunction

    function void set_access();
      for (int i = 0; i < AF; i++) opnd[i] = acc_feat[i];
    endfunction

    function void set_hidden();
      for (int i = 0; i < HU; i++) opnd[i] = hidden[i];
    endfunction

    // One recurrent update of the hidden vector.
    function void gru_update();
      shortint rh [HU];
      int unsigned zg [HU];
      int unsigned r;
      int acc;
      longint cand, mix;
      for (int i = 0; i < HU; i++) begin
        set_access();
        acc = mac(0, W_IR + i * AF, AF);
        set_hidden();
        acc = mac(acc, W_HR + i * HU, HU);
        acc = add_bias(add_bias(acc, B_IR + i), B_IRH + i);
        r = sig_lut[lut_idx(q12(acc))];
        set_access();
        acc = mac(0, W_IZ + i * AF, AF);
        set_hidden();
        acc = mac(acc, W_HZ + i * HU, HU);
        acc = add_bias(add_bias(acc, B_IZ + i), B_IZH + i);
        zg[i] = sig_lut[lut_idx(q12(acc))];
        rh[i] = sat16((longint'(r) * longint'(hidden[i])) >>> 16);
      end
      for (int i = 0; i < HU; i++) begin
        set_access();
        acc = mac(0, W_IN + i * AF, AF);
        for (int j = 0; j < HU; j++) opnd[j] = rh[j];
        acc = mac(acc, W_HN + i * HU, HU);
        acc = add_bias(add_bias(acc, B_IN + i), B_HN + i);
        cand = tanh_lut[lut_idx(q12(acc))];
        mix = longint'(65536 - zg[i]) * cand + longint'(zg[i]) * longint'(hidden[i]);
        hidden[i] = sat16(mix >>> 16);
      end
    endfunction

    // Two ReLU layers and a sigmoid output over hidden joined with page features.
    function logic [15:0] reuse_score();
      shortint a1 [L1];
      shortint a2 [L2];
      shortint v;
      int acc;
      for (int i = 0; i < L1; i++) begin
        for (int j = 0; j < HU; j++) opnd[j] = hidden[j];
        for (int j = 0; j < PF; j++) opnd[HU + j] = page_feat[j];
        acc = add_bias(mac(0, FC1_W + i * SIN, SIN), FC1_B + i);
        v = q12(acc);
        a1[i] = (v > 0) ? v : 0;
      end
      for (int i = 0; i < L2; i++) begin
        for (int j = 0; j < L1; j++) opnd[j] = a1[j];
        acc = add_bias(mac(0, FC2_W + i * L1, L1), FC2_B + i);
        v = q12(acc);
        a2[i] = (v > 0) ? v : 0;
      end
      for (int j = 0; j < L2; j++) opnd[j] = a2[j];
      acc = add_bias(mac(0, OUT_W, L2), OUT_B);
      return sig_lut[lut_idx(q12(acc))];
    endfunction

    // Updates the state for one accepted input transfer.
    function void note_item(gru_pkg::kind_t k, logic [11:0] wi, logic [2:0] ei,
                            logic signed [15:0] val, logic lst);
      case (k)
        gru_pkg::KIND_LOAD: begin
          wmem[wi] = val;
        end
        gru_pkg::KIND_ACCESS: begin
          if (ei < AF) acc_feat[ei] = val;
          if (lst) gru_update();
        end
        gru_pkg::KIND_PAGE: begin
          if (ei < PF) page_feat[ei] = val;
          if (lst) prob_q.push_back(reuse_score());
        end
        default: begin
          foreach (hidden[i]) hidden[i] = 0;
        end
      endcase
    endfunction

    function void check_result(logic [15:0] actual);
      logic [15:0] want;
      if (prob_q.size() == 0) begin
        $error("reuse_probability: expected none, actual %0d", actual);
        errors++;
        return;
      end
      want = prob_q.pop_front();
      if (actual !== want) begin
        $error("reuse_probability: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = gru_pkg::KIND_LOAD;
  logic [11:0] weight_index = '0;
  logic [2:0] element_index = '0;
  logic signed [15:0] value = '0;
  logic last = 1'b0;
  logic done;
  logic [15:0] reuse_probability;

  reuse_scoreboard sb = new();
  int burst_left = 0;

  gru_cell_with_reuse_scorer u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .weight_index(weight_index),
    .element_index(element_index),
    .value(value),
    .last(last),
    .done(done),
    .reuse_probability(reuse_probability)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every strobed result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(reuse_probability);
    end
  end

  // Presents one item and holds it until the block takes the transfer.
  task automatic send_item(gru_pkg::kind_t k, logic [11:0] wi, logic [2:0] ei,
                           logic signed [15:0] val, logic lst);
    @(negedge clk);
    start = 1'b1;
    kind = k;
    weight_index = wi;
    element_index = ei;
    value = val;
    last = lst;
    do @(posedge clk); while (busy);
    sb.note_item(k, wi, ei, val, lst);
  endtask

  // Sender works in bursts; between bursts start may drop for a random gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] rand_weight();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 3000)) - 1500);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_feature();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  // A feature vector of random length and order, last on its final element.
  task automatic send_vector(gru_pkg::kind_t k);
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_item(k, 12'($urandom), 3'($urandom), rand_feature(), i == n - 1);
      pace();
    end
  endtask

  initial begin
    int sent;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole parameter layout, then a few words past it.
    for (int a = 0; a < USED_WORDS; a++) begin
      send_item(gru_pkg::KIND_LOAD, 12'(a), 3'($urandom), rand_weight(), 1'($urandom));
      pace();
    end
    for (int i = 0; i < 30; i++) begin
      send_item(gru_pkg::KIND_LOAD, 12'($urandom_range(USED_WORDS, 4095)), 3'($urandom),
                16'($urandom), 1'($urandom));
    end
    send_item(gru_pkg::KIND_LOAD, 12'hFFF, 3'd7, 16'sh7FFF, 1'b1);

    // Directed part: full vectors at the value extremes, a score from a
    // cleared hidden vector, and element writes without last.
    for (int i = 0; i < AF; i++) begin
      send_item(gru_pkg::KIND_ACCESS, 12'hFFF, 3'(i), (i % 2) ? 16'sh7FFF : 16'sh8000,
                i == AF - 1);
    end
    for (int i = 0; i < PF; i++) begin
      send_item(gru_pkg::KIND_PAGE, 12'h000, 3'(i), (i % 2) ? 16'sh8000 : 16'sh7FFF,
                i == PF - 1);
    end
    send_item(gru_pkg::KIND_CLEAR, 12'hABC, 3'd5, 16'sh1234, 1'b1);
    send_item(gru_pkg::KIND_PAGE, 12'h000, 3'd0, 16'sh0000, 1'b1);
    send_item(gru_pkg::KIND_ACCESS, 12'h000, 3'd3, 16'sh0000, 1'b1);
    send_item(gru_pkg::KIND_PAGE, 12'h555, 3'd7, 16'sh1000, 1'b1);
    send_item(gru_pkg::KIND_CLEAR, 12'h000, 3'd0, 16'sh0000, 1'b0);

    // Random part: mostly well-formed vectors, with clears and weight rewrites.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(gru_pkg::KIND_CLEAR, 12'($urandom), 3'($urandom), 16'($urandom),
                    1'($urandom));
          pace();
          sent++;
        end
        1, 2: begin
          send_item(gru_pkg::KIND_LOAD, 12'($urandom_range(0, USED_WORDS - 1)),
                    3'($urandom), rand_weight(), 1'($urandom));
          pace();
          sent++;
        end
        3, 4, 5, 6, 7, 8, 9, 10: begin
          send_vector(gru_pkg::KIND_ACCESS);
          sent += 4;
        end
        default: begin
          send_vector(gru_pkg::KIND_PAGE);
          sent += 4;
        end
      endcase
    end
    @(negedge clk);
    start = 1'b0;

    // Drain outstanding scores, then let any trailing update finish.
    while (sb.prob_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on the run length.
  initial begin
    #(12 * 4000000);
    $display("simulation failed");
    $finish;
  end

endmodule
